@@ rtl/core/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants for the convex polygon point test unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cpt_pkg;

  // Default polygon store depth
  localparam int MAX_VERTICES_DEF = 16;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 4;

  // Vertex count after reset
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd3;

  // Input operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // One stored vertex: x in the low half, y in the high half
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  // Control tag that travels with an edge into the cross product unit
  typedef struct packed {
    logic valid;
    logic last;
  } edge_tag_t;

  // Edge sign coming back from the cross product unit
  typedef struct packed {
    logic valid;
    logic last;
    logic positive;
  } edge_res_t;

endpackage

`default_nettype wire

@@ rtl/core/cpt_edge_unit.sv @@
// ----------------------------------------------------------------------------
// cpt_edge_unit
// Shared pipelined cross product unit: one edge per cycle, three stages.
// Gives whether cross(p - a, b - a) is strictly positive.
// ----------------------------------------------------------------------------
`default_nettype none

module cpt_edge_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cpt_pkg::edge_tag_t tag_in,
  input  wire cpt_pkg::vertex_t   va,
  input  wire cpt_pkg::vertex_t   vb,
  input  wire cpt_pkg::vertex_t   pt,
  output cpt_pkg::edge_res_t      res
);
  import cpt_pkg::*;

  localparam int DW = COORD_W + 1;
  localparam int PW = 2 * DW;

  edge_tag_t              tag_d;
  edge_tag_t              tag_p;
  logic signed [DW-1:0]   dxp;
  logic signed [DW-1:0]   dyp;
  logic signed [DW-1:0]   dxe;
  logic signed [DW-1:0]   dye;
  logic signed [PW-1:0]   prod_a;
  logic signed [PW-1:0]   prod_b;
  logic signed [PW:0]     cross_prod;

  // Stage 3 subtract, exact in 35 bits
  assign cross_prod = $signed({prod_a[PW-1], prod_a}) - $signed({prod_b[PW-1], prod_b});

  // Stage control tags and the strict sign of the cross product
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d <= '0;
      tag_p <= '0;
      res   <= '0;
    end else begin
      tag_d        <= tag_in;
      tag_p        <= tag_d;
      res.valid    <= tag_p.valid;
      res.last     <= tag_p.last;
      res.positive <= !cross_prod[PW] && (cross_prod != '0);
    end
  end

  // Stage 1: coordinate differences, exact in 17 bits
  always_ff @(posedge clk) begin
    dxp <= $signed({pt.x[COORD_W-1], pt.x}) - $signed({va.x[COORD_W-1], va.x});
    dyp <= $signed({pt.y[COORD_W-1], pt.y}) - $signed({va.y[COORD_W-1], va.y});
    dxe <= $signed({vb.x[COORD_W-1], vb.x}) - $signed({va.x[COORD_W-1], va.x});
    dye <= $signed({vb.y[COORD_W-1], vb.y}) - $signed({va.y[COORD_W-1], va.y});
  end

  // Stage 2: multiplier pair, 17 by 17 signed
  always_ff @(posedge clk) begin
    prod_a <= PW'(dxp) * PW'(dye);
    prod_b <= PW'(dyp) * PW'(dxe);
  end

endmodule

`default_nettype wire

@@ rtl/core/convex_polygon_point_test_unit.sv @@
// A load gives no result. A test gives one inside flag; no new item is taken
// until that flag is registered at the output, which waits while the previous
// flag is still held there. The read port walks the N + 1 vertex reads, one per
// cycle, through the unit, N being the vertex count in use.
// Reset: synchronous, active high; clears control state and sets the vertex
// count to 3. The vertex store is not cleared.
// ----------------------------------------------------------------------------
// convex_polygon_point_test_unit
// Vertex store plus an edge sequencer that reports whether a point lies
// inside the stored convex polygon.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_point_test_unit #(
  parameter int MAX_VERTICES = cpt_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          vertex_count_we,
  input  wire logic [cpt_pkg::COUNT_W-1:0]   vertex_count_wdata,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic [cpt_pkg::INDEX_W-1:0]   vertex_index,
  input  wire logic signed [cpt_pkg::COORD_W-1:0] coord_x,
  input  wire logic signed [cpt_pkg::COORD_W-1:0] coord_y,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               inside_res
);
  import cpt_pkg::*;

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } read_tag_t;

  // Vertex store
  vertex_t         mem [MAX_VERTICES];
  vertex_t         rd_data;
  logic [IW-1:0]   rd_addr;
  logic            mem_we;
  logic [IW-1:0]   wr_addr;

  // Control and datapath registers
  state_t          state, state_next;
  logic [COUNT_W-1:0] vertex_count;
  logic [CW-1:0]   n_eff;
  logic [CW-1:0]   rd_cnt, rd_cnt_next;
  read_tag_t       rd_tag, rd_tag_next;
  vertex_t         point;
  vertex_t         prev;
  logic            any_pos, any_pos_next;
  logic            any_nonpos, any_nonpos_next;
  logic            res_pend, res_pend_next;
  logic            out_valid_next;
  logic            inside_res_next;
  logic            pos_f;
  logic            nonpos_f;
  logic            in_fire;
  edge_tag_t       edge_tag;
  edge_res_t       edge_res;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Effective vertex count: zero means one, clamp to the store depth
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vertex_count);
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_RESET;
    end else if (vertex_count_we) begin
      vertex_count <= vertex_count_wdata;
    end
  end

  // Store write for a load transaction; slots past the depth are dropped
  assign wr_addr = IW'(vertex_index);
  assign mem_we  = in_fire && (op == OP_LOAD) && (32'(vertex_index) < MAX_VERTICES);

  // Read walks slots 0 .. N-1, then slot 0 again for the closing edge
  assign rd_addr = (rd_cnt == n_eff) ? '0 : rd_cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= '{y: coord_y, x: coord_x};
    end
    rd_data <= mem[rd_addr];
  end

  // Point capture and previous vertex
  always_ff @(posedge clk) begin
    if (in_fire) begin
      point <= '{y: coord_y, x: coord_x};
    end
    if (rd_tag.valid) begin
      prev <= rd_data;
    end
  end

  // Edge from previous vertex to the one just read
  assign edge_tag.valid = rd_tag.valid && !rd_tag.first;
  assign edge_tag.last  = rd_tag.last;

  cpt_edge_unit u_edge (
    .clk    (clk),
    .rst    (rst),
    .tag_in (edge_tag),
    .va     (prev),
    .vb     (rd_data),
    .pt     (point),
    .res    (edge_res)
  );

  // Sign flags including the edge arriving now
  assign pos_f    = any_pos || edge_res.positive;
  assign nonpos_f = any_nonpos || !edge_res.positive;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_cnt     <= '0;
      rd_tag     <= '0;
      any_pos    <= 1'b0;
      any_nonpos <= 1'b0;
      res_pend   <= 1'b0;
      out_valid  <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      state      <= state_next;
      rd_cnt     <= rd_cnt_next;
      rd_tag     <= rd_tag_next;
      any_pos    <= any_pos_next;
      any_nonpos <= any_nonpos_next;
      res_pend   <= res_pend_next;
      out_valid  <= out_valid_next;
      inside_res <= inside_res_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    rd_cnt_next     = rd_cnt;
    rd_tag_next     = '0;
    any_pos_next    = any_pos;
    any_nonpos_next = any_nonpos;
    res_pend_next   = res_pend;
    out_valid_next  = out_valid && !out_ready;
    inside_res_next = inside_res;

    // fold in each edge sign as it comes back
    if (edge_res.valid) begin
      any_pos_next    = pos_f;
      any_nonpos_next = nonpos_f;
    end

    case (state)
      ST_IDLE: begin
        if (in_fire && (op == OP_TEST)) begin
          rd_cnt_next     = '0;
          any_pos_next    = 1'b0;
          any_nonpos_next = 1'b0;
          state_next      = ST_RUN;
        end
      end
      ST_RUN: begin
        rd_tag_next.valid = 1'b1;
        rd_tag_next.first = (rd_cnt == '0);
        rd_tag_next.last  = (rd_cnt == n_eff);
        rd_cnt_next       = rd_cnt + CW'(1);
        if (rd_cnt == n_eff) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (edge_res.valid && edge_res.last) begin
          res_pend_next = !(pos_f && nonpos_f);
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          inside_res_next = res_pend;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the convex polygon point test unit. Vertex loads
// and point tests go in over a valid/ready channel; a shadow copy of the
// vertex store and count predicts each inside flag with exact cross products,
// and a monitor compares every returned flag in order. Directed polygons come
// first, then random convex and scattered polygons under several idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import cpt_pkg::*;

  localparam int SETTLE_CYCLES = 40;    // settle time after the last flag, longer than one test at the largest count
  localparam int STALL_LIMIT   = 5000;  // cycles with no transaction at all
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int PHASE_ITEMS   = 420;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      vertex_count_we = 1'b0;
  logic [COUNT_W-1:0]        vertex_count_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      op = 1'b0;
  logic [INDEX_W-1:0]        vertex_index = '0;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      inside_res;

  // Shadow state and pending inside flags
  vertex_t            vertex_shadow [MAX_VERTICES_DEF];
  logic [COUNT_W-1:0] count_shadow = COUNT_RESET;
  logic               pending_inside [$];

  int error_count    = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  // Current polygon under test
  int poly_x [MAX_VERTICES_DEF];
  int poly_y [MAX_VERTICES_DEF];
  int poly_cx;
  int poly_cy;
  int poly_r;

  always #1 clk = ~clk;

  convex_polygon_point_test_unit #(
    .MAX_VERTICES(MAX_VERTICES_DEF)
  ) u_top (
    .clk                (clk),
    .rst                (rst),
    .vertex_count_we    (vertex_count_we),
    .vertex_count_wdata (vertex_count_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .op                 (op),
    .vertex_index       (vertex_index),
    .coord_x            (coord_x),
    .coord_y            (coord_y),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .inside_res         (inside_res)
  );

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // All edge signs must agree; zero counts as not positive
  function automatic logic predict_inside(input logic signed [COORD_W-1:0] px,
                                          input logic signed [COORD_W-1:0] py);
    int     n;
    int     i;
    int     j;
    longint dxp;
    longint dyp;
    longint dxe;
    longint dye;
    logic   seen_pos;
    logic   seen_nonpos;
    n = count_shadow;
    if (n > MAX_VERTICES_DEF) n = MAX_VERTICES_DEF;
    if (n == 0) n = 1;
    seen_pos = 1'b0;
    seen_nonpos = 1'b0;
    for (i = 0; i < n; i++) begin
      j   = (i + 1) % n;
      dxp = longint'(px) - longint'($signed(vertex_shadow[i].x));
      dyp = longint'(py) - longint'($signed(vertex_shadow[i].y));
      dxe = longint'($signed(vertex_shadow[j].x)) - longint'($signed(vertex_shadow[i].x));
      dye = longint'($signed(vertex_shadow[j].y)) - longint'($signed(vertex_shadow[i].y));
      if (dxp * dye - dyp * dxe > 0) seen_pos = 1'b1;
      else seen_nonpos = 1'b1;
    end
    return !(seen_pos && seen_nonpos);
  endfunction

  function automatic logic signed [COORD_W-1:0] to_coord(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return COORD_W'(v);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int spread(input int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  // One input transaction; returns at the accepting rising edge
  task automatic send_item(input op_t kind, input logic [INDEX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    vertex_index <= idx;
    coord_x      <= x;
    coord_y      <= y;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (kind == OP_LOAD) begin
      vertex_shadow[idx].x = x;
      vertex_shadow[idx].y = y;
    end else begin
      pending_inside = {pending_inside, predict_inside(x, y)};
    end
  endtask

  // Drop valid and wait until every flag is back and the block is quiet
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_inside.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    @(negedge clk);
    vertex_count_we    <= 1'b1;
    vertex_count_wdata <= value;
    @(negedge clk);
    vertex_count_we    <= 1'b0;
    count_shadow = value;
  endtask

  // Convex polygon on a circle, or scattered points when scatter is set
  task automatic build_polygon(input int n, input bit scatter);
    int  w [MAX_VERTICES_DEF];
    int  wsum;
    int  acc;
    int  i;
    bit  clockwise;
    real start;
    real ang;
    if (scatter) begin
      poly_cx = 0;
      poly_cy = 0;
      poly_r  = 32767;
      for (i = 0; i < n; i++) begin
        poly_x[i] = rand_coord();
        poly_y[i] = rand_coord();
      end
    end else begin
      poly_r  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 40))
                                            : int'($urandom_range(100, 30000));
      poly_cx = spread(32767 - poly_r);
      poly_cy = spread(32767 - poly_r);
      clockwise = $urandom_range(0, 1);
      start = $urandom_range(0, 6283) / 1000.0;
      wsum = 0;
      for (i = 0; i < n; i++) begin
        w[i] = $urandom_range(1, 100);
        wsum += w[i];
      end
      acc = 0;
      for (i = 0; i < n; i++) begin
        ang = start + 6.283185307 * acc / wsum;
        acc += w[i];
        poly_x[i] = poly_cx + $rtoi(poly_r * $cos(ang));
        poly_y[i] = clockwise ? poly_cy - $rtoi(poly_r * $sin(ang))
                              : poly_cy + $rtoi(poly_r * $sin(ang));
      end
    end
  endtask

  // Load slots 0..n-1, starting at a random slot
  task automatic load_polygon(input int n);
    int i;
    int rot;
    int s;
    rot = $urandom_range(0, n - 1);
    for (i = 0; i < n; i++) begin
      s = (i + rot) % n;
      send_item(OP_LOAD, INDEX_W'(s), to_coord(poly_x[s]), to_coord(poly_y[s]));
    end
  endtask

  // Point near the current polygon, on it, or anywhere
  task automatic send_query(input int n);
    int k;
    int m;
    int x;
    int y;
    k = $urandom_range(0, n - 1);
    m = (k + 1) % n;
    case ($urandom_range(0, 5))
      0: begin
        x = poly_cx + spread(poly_r / 4);
        y = poly_cy + spread(poly_r / 4);
      end
      1: begin
        x = poly_x[k];
        y = poly_y[k];
      end
      2: begin
        x = (poly_x[k] + poly_x[m]) / 2;
        y = (poly_y[k] + poly_y[m]) / 2;
      end
      3: begin
        x = poly_cx + spread(poly_r);
        y = poly_cy + spread(poly_r);
      end
      4: begin
        x = rand_coord();
        y = rand_coord();
      end
      default: begin
        x = poly_x[k] + spread(1);
        y = poly_y[k] + spread(1);
      end
    endcase
    send_item(OP_TEST, INDEX_W'($urandom_range(0, 15)), to_coord(x), to_coord(y));
  endtask

  // Reset count of 3 on an extreme square: lower-right triangle
  task automatic test_reset_triangle();
    send_item(OP_LOAD, 0, -32768, -32768);
    send_item(OP_LOAD, 1, 32767, -32768);
    send_item(OP_LOAD, 2, 32767, 32767);
    send_item(OP_LOAD, 3, -32768, 32767);
    send_item(OP_TEST, 4'hF, 16000, -16000);
    send_item(OP_TEST, 0, -16000, 16000);
    send_item(OP_TEST, 4'hA, -32768, -32768);
    send_item(OP_TEST, 5, 0, 0);
  endtask

  // Full square, then single vertex and zero count
  task automatic test_square_and_counts();
    write_vertex_count(4);
    send_item(OP_TEST, 0, 0, 0);
    send_item(OP_TEST, 4'hF, -32768, 0);
    send_item(OP_TEST, 3, 32767, -32768);
    send_item(OP_TEST, 9, -1, -1);
    write_vertex_count(1);
    send_item(OP_TEST, 0, 123, -456);
    write_vertex_count(0);
    send_item(OP_TEST, 0, 7, 7);
  endtask

  // Every slot written, one repeated vertex, counts at and above the store size
  task automatic test_full_store();
    build_polygon(MAX_VERTICES_DEF, 1'b0);
    poly_x[15] = poly_x[14];
    poly_y[15] = poly_y[14];
    write_vertex_count(16);
    load_polygon(MAX_VERTICES_DEF);
    send_item(OP_TEST, 0, to_coord(poly_cx), to_coord(poly_cy));
    send_query(MAX_VERTICES_DEF);
    write_vertex_count(31);
    send_item(OP_TEST, 0, to_coord(poly_x[15]), to_coord(poly_y[15]));
    send_query(MAX_VERTICES_DEF);
    write_vertex_count(17);
    send_item(OP_TEST, 0, to_coord(poly_cx), to_coord(poly_cy));
    send_query(MAX_VERTICES_DEF);
  endtask

  // Receiver holds off while tests keep coming, so the input backs up
  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    build_polygon(8, 1'b0);
    write_vertex_count(8);
    load_polygon(8);
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 40; i++) send_query(8);
    wait_drained();
  endtask

  // Random polygons; about one round in five is noise or broken
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int quota);
    int first;
    int n;
    int nq;
    int q;
    bit noise;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = items_sent;
    while (items_sent - first < quota) begin
      noise = ($urandom_range(0, 99) < 20);
      n = $urandom_range(1, MAX_VERTICES_DEF);
      write_vertex_count(COUNT_W'(noise ? $urandom_range(0, 31) : n));
      build_polygon(n, noise && $urandom_range(0, 1));
      load_polygon(n);
      nq = $urandom_range(n, 3 * n + 4);
      for (q = 0; q < nq; q++) begin
        if (noise && $urandom_range(0, 9) == 0)
          send_item(OP_LOAD, INDEX_W'($urandom_range(0, 15)), to_coord(rand_coord()),
                    to_coord(rand_coord()));
        send_query(n);
      end
    end
  endtask

  // Receiver ready: random stalls or a counted hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Result check against the oldest pending flag
  always @(posedge clk) begin : check_results
    logic want;
    if (!rst && out_valid && out_ready) begin
      if (pending_inside.size() == 0) begin
        report_mismatch("inside_res transaction with no test pending");
      end else begin
        want = pending_inside.pop_front();
        if (inside_res !== want)
          report_mismatch($sformatf("inside_res got %b expected %b", inside_res, want));
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Test sequence
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_triangle();
    test_square_and_counts();
    test_full_store();
    test_backpressure();
    run_random_phase(0, 0, PHASE_ITEMS);
    run_random_phase(76, 0, PHASE_ITEMS);
    run_random_phase(0, 76, PHASE_ITEMS);
    run_random_phase(24, 24, PHASE_ITEMS);
    wait_drained();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cpt_pkg.sv
rtl/core/cpt_edge_unit.sv
rtl/core/convex_polygon_point_test_unit.sv
tb/sv/tb_top.sv
